[rtl/tpl_pkg.sv]
// Shared types, widths, register codes and reset values for the trapezoid pulse level block.
// Used by the channel interfaces, the modulo pipeline, the divider pipeline and the top level.
// Has no dependencies of its own.
package tpl_pkg;

   // Field widths fixed by the block's interface.
   localparam int TIME_BITS  = 48;
   localparam int LEVEL_BITS = 16;
   localparam int CFG_W      = 32;
   localparam int AMP_W      = 16;
   localparam int FACT_W     = 16;
   localparam int FRAC_BITS  = 15;

   // Derived arithmetic widths.
   // The period is the sum of two 32-bit times.
   localparam int PER_W     = CFG_W + 1;
   // The magnitude is at most 2^(AMP_W-1), so magnitude * factor stays below 2^PROD_W.
   localparam int PROD_W    = AMP_W - 1 + FACT_W;
   localparam int NUM_W     = PROD_W + CFG_W;
   localparam int DIV_N_W   = NUM_W - FRAC_BITS;
   // The scaled level always fits in this many quotient bits.
   localparam int QUOT_W    = DIV_N_W - CFG_W;
   localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
   localparam int SAT_W     = ((QUOT_W > LEVEL_BITS) ? QUOT_W : LEVEL_BITS) + 1;

   localparam int MOD_STAGES = TIME_BITS;
   localparam int DIV_STAGES = QUOT_W;

   typedef logic [TIME_BITS-1:0]         time_type;
   typedef logic [FACT_W-1:0]            factor_type;
   typedef logic signed [LEVEL_BITS-1:0] level_type;
   typedef logic [CFG_W-1:0]             cfg_type;
   typedef logic [PER_W-1:0]             per_type;
   typedef logic [QUOT_W-1:0]            quot_type;
   typedef logic [SAT_W-1:0]             sat_type;

   // Saturation limits, as output codes and as magnitudes.
   localparam logic [LEVEL_BITS-1:0] LEVEL_POS_LIMIT = {1'b0, {(LEVEL_BITS-1){1'b1}}};
   localparam logic [LEVEL_BITS-1:0] LEVEL_NEG_LIMIT = {1'b1, {(LEVEL_BITS-1){1'b0}}};
   localparam sat_type SAT_POS_LIMIT = {{(SAT_W-LEVEL_BITS){1'b0}}, LEVEL_POS_LIMIT};
   localparam sat_type SAT_NEG_LIMIT = {{(SAT_W-LEVEL_BITS){1'b0}}, LEVEL_NEG_LIMIT};

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_TIME   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_TIME    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_TIME   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_TIME   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DELAY = 3'd5;

   // Register values after reset.
   localparam logic [AMP_W-1:0] RST_AMPLITUDE   = 16'h7FFF;
   localparam cfg_type          RST_HIGH_TIME   = 32'd1000000;
   localparam cfg_type          RST_LOW_TIME    = 32'd1000000;
   localparam cfg_type          RST_RISE_TIME   = 32'd1;
   localparam cfg_type          RST_FALL_TIME   = 32'd1;
   localparam cfg_type          RST_START_DELAY = 32'd0;

   // Side information that rides along with the modulo pipeline.
   typedef struct packed {
      logic       live;
      factor_type factor;
   } mod_side_type;

endpackage

[rtl/tpl_if.sv]
// Request and response channel interfaces of the trapezoid pulse level block.
// Depends on tpl_pkg for the field widths.
interface tpl_req_if;
   logic                valid;
   logic                ready;
   tpl_pkg::time_type   time_now;
   tpl_pkg::factor_type source_factor;

   modport source (output valid, output time_now, output source_factor, input ready);
   modport sink (input valid, input time_now, input source_factor, output ready);
endinterface

interface tpl_rsp_if;
   logic               valid;
   logic               ready;
   tpl_pkg::level_type drive_level;

   modport source (output valid, output drive_level, input ready);
   modport sink (input valid, input drive_level, output ready);
endinterface

[rtl/tpl_mod_pipe.sv]
// Pipelined remainder unit: dividend modulo period, one dividend bit per stage.
// Depends on tpl_pkg for widths and the side information type.
module tpl_mod_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  tpl_pkg::time_type     in_dividend,
   input  tpl_pkg::mod_side_type in_side,
   input  tpl_pkg::per_type      period,
   output logic                  out_valid,
   output tpl_pkg::per_type      out_phase,
   output tpl_pkg::mod_side_type out_side
);

   logic [tpl_pkg::MOD_STAGES-1:0] valid_ff;
   logic [tpl_pkg::MOD_STAGES-1:0] valid_in;
   tpl_pkg::per_type      rem_ff  [tpl_pkg::MOD_STAGES];
   tpl_pkg::per_type      rem_in  [tpl_pkg::MOD_STAGES];
   tpl_pkg::time_type     dvd_ff  [tpl_pkg::MOD_STAGES];
   tpl_pkg::time_type     dvd_in  [tpl_pkg::MOD_STAGES];
   tpl_pkg::mod_side_type side_ff [tpl_pkg::MOD_STAGES];
   tpl_pkg::mod_side_type side_in [tpl_pkg::MOD_STAGES];
   tpl_pkg::per_type      prev_rem [tpl_pkg::MOD_STAGES];
   tpl_pkg::time_type     prev_dvd [tpl_pkg::MOD_STAGES];
   logic [tpl_pkg::PER_W:0] trial [tpl_pkg::MOD_STAGES];
   logic [tpl_pkg::PER_W:0] sub   [tpl_pkg::MOD_STAGES];

   // Stage inputs: the first stage starts from a zero remainder.
   always_comb begin
      prev_rem[0] = '0;
      prev_dvd[0] = in_dividend;
      side_in[0]  = in_side;
      for (int k = 1; k < tpl_pkg::MOD_STAGES; k++) begin
         prev_rem[k] = rem_ff[k-1];
         prev_dvd[k] = dvd_ff[k-1];
         side_in[k]  = side_ff[k-1];
      end
   end

   // Each stage shifts in the next dividend bit and subtracts the period when it fits.
   always_comb begin
      for (int k = 0; k < tpl_pkg::MOD_STAGES; k++) begin
         trial[k]  = {prev_rem[k], prev_dvd[k][tpl_pkg::TIME_BITS-1]};
         sub[k]    = trial[k] - {1'b0, period};
         if (trial[k] >= {1'b0, period}) begin
            rem_in[k] = sub[k][tpl_pkg::PER_W-1:0];
         end else begin
            rem_in[k] = trial[k][tpl_pkg::PER_W-1:0];
         end
         dvd_in[k] = prev_dvd[k] << 1;
      end
   end

   assign valid_in = {valid_ff[tpl_pkg::MOD_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         dvd_ff  <= dvd_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[tpl_pkg::MOD_STAGES-1];
   assign out_phase = rem_ff[tpl_pkg::MOD_STAGES-1];
   assign out_side  = side_ff[tpl_pkg::MOD_STAGES-1];

   // A finished remainder is always below a nonzero period.
   a_phase_below_period: assert property (@(posedge clock) disable iff (reset)
      (out_valid && (period != '0)) |-> (out_phase < period))
      else $error("remainder is not below the period");

endmodule

[rtl/tpl_div_pipe.sv]
// Pipelined restoring divider: a scaled product divided by a ramp length, one quotient
// bit per stage. Depends on tpl_pkg for widths.
module tpl_div_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [tpl_pkg::DIV_N_W-1:0] in_num,
   input  tpl_pkg::cfg_type            in_len,
   output logic                        out_valid,
   output tpl_pkg::quot_type           out_quot
);

   logic [tpl_pkg::DIV_STAGES-1:0] valid_ff;
   logic [tpl_pkg::DIV_STAGES-1:0] valid_in;
   tpl_pkg::cfg_type  rem_ff  [tpl_pkg::DIV_STAGES];
   tpl_pkg::cfg_type  rem_in  [tpl_pkg::DIV_STAGES];
   tpl_pkg::quot_type low_ff  [tpl_pkg::DIV_STAGES];
   tpl_pkg::quot_type low_in  [tpl_pkg::DIV_STAGES];
   tpl_pkg::quot_type quot_ff [tpl_pkg::DIV_STAGES];
   tpl_pkg::quot_type quot_in [tpl_pkg::DIV_STAGES];
   tpl_pkg::cfg_type  len_ff  [tpl_pkg::DIV_STAGES];
   tpl_pkg::cfg_type  len_in  [tpl_pkg::DIV_STAGES];
   tpl_pkg::cfg_type  prev_rem  [tpl_pkg::DIV_STAGES];
   tpl_pkg::quot_type prev_low  [tpl_pkg::DIV_STAGES];
   tpl_pkg::quot_type prev_quot [tpl_pkg::DIV_STAGES];
   logic [tpl_pkg::CFG_W:0] trial [tpl_pkg::DIV_STAGES];
   logic [tpl_pkg::CFG_W:0] sub   [tpl_pkg::DIV_STAGES];
   logic [tpl_pkg::DIV_STAGES-1:0] fits;

   // The upper part of the numerator is already below the length, so only the low
   // quotient bits need stages.
   always_comb begin
      prev_rem[0]  = in_num[tpl_pkg::DIV_N_W-1:tpl_pkg::QUOT_W];
      prev_low[0]  = in_num[tpl_pkg::QUOT_W-1:0];
      prev_quot[0] = '0;
      len_in[0]    = in_len;
      for (int k = 1; k < tpl_pkg::DIV_STAGES; k++) begin
         prev_rem[k]  = rem_ff[k-1];
         prev_low[k]  = low_ff[k-1];
         prev_quot[k] = quot_ff[k-1];
         len_in[k]    = len_ff[k-1];
      end
   end

   // Each stage brings down one numerator bit and decides one quotient bit.
   always_comb begin
      for (int k = 0; k < tpl_pkg::DIV_STAGES; k++) begin
         trial[k] = {prev_rem[k], prev_low[k][tpl_pkg::QUOT_W-1]};
         sub[k]   = trial[k] - {1'b0, len_in[k]};
         fits[k]  = (trial[k] >= {1'b0, len_in[k]});
         if (fits[k]) begin
            rem_in[k] = sub[k][tpl_pkg::CFG_W-1:0];
         end else begin
            rem_in[k] = trial[k][tpl_pkg::CFG_W-1:0];
         end
         low_in[k]  = prev_low[k] << 1;
         quot_in[k] = {prev_quot[k][tpl_pkg::QUOT_W-2:0], fits[k]};
      end
   end

   assign valid_in = {valid_ff[tpl_pkg::DIV_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         quot_ff <= quot_in;
         len_ff  <= len_in;
      end
   end

   assign out_valid = valid_ff[tpl_pkg::DIV_STAGES-1];
   assign out_quot  = quot_ff[tpl_pkg::DIV_STAGES-1];

   // The quotient must fit its bits: the numerator's upper part starts below the length.
   a_quotient_fits: assert property (@(posedge clock) disable iff (reset)
      (en && in_valid) |-> (in_num[tpl_pkg::DIV_N_W-1:tpl_pkg::QUOT_W] < in_len))
      else $error("divider quotient would overflow");

endmodule

[rtl/trapezoid_pulse_level.sv]
// Trapezoid pulse level: one request is taken per cycle while the skid register is empty.
// An accepted request passes the entry stage, the bit-per-stage modulo pipeline, the classify
// and multiply stages, the 16-stage level divider and the saturate stage to the output register.
// A response that is not taken parks in a skid register, and the pipeline holds while it is full.
// Synchronous active-high reset empties the pipeline and restores the register defaults.
// Depends on tpl_pkg, tpl_if, tpl_mod_pipe and tpl_div_pipe.
module trapezoid_pulse_level (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [tpl_pkg::CSR_IDX_W-1:0] csr_index,
   input  tpl_pkg::cfg_type              csr_wdata,
   tpl_req_if.sink                       req_chan,
   tpl_rsp_if.source                     rsp_chan
);

   // Configuration registers.
   logic [tpl_pkg::AMP_W-1:0] amp_ff, amp_in;
   tpl_pkg::cfg_type high_ff, high_in;
   tpl_pkg::cfg_type low_ff, low_in;
   tpl_pkg::cfg_type rise_ff, rise_in;
   tpl_pkg::cfg_type fall_ff, fall_in;
   tpl_pkg::cfg_type dly_ff, dly_in;

   // Values derived from the configuration.
   logic [tpl_pkg::AMP_W-1:0] mag_ff, mag_in;
   logic             neg_ff, neg_in;
   tpl_pkg::cfg_type tr_ff, tr_in;
   tpl_pkg::cfg_type tf_ff, tf_in;
   tpl_pkg::per_type period_ff, period_in;
   tpl_pkg::per_type thf_ff, thf_in;

   logic en;

   // Entry stage.
   logic [tpl_pkg::CMP_W-1:0] t_ext, dly_ext, diff;
   logic                  a_valid_ff;
   tpl_pkg::time_type     a_dt_ff, a_dt_in;
   tpl_pkg::mod_side_type a_side_ff, a_side_in;

   // Modulo pipeline outputs.
   logic                  m_valid;
   tpl_pkg::per_type      m_phase;
   tpl_pkg::mod_side_type m_side;

   // Classify stage.
   logic                  c_valid_ff;
   tpl_pkg::cfg_type      c_x_ff, c_x_in;
   tpl_pkg::cfg_type      c_len_ff, c_len_in;
   logic [tpl_pkg::PROD_W-1:0] c_ms_ff, c_ms_in;
   logic [tpl_pkg::AMP_W+tpl_pkg::FACT_W-1:0] ms_full;
   tpl_pkg::per_type      fall_x;

   // Multiply stage.
   logic                       mm_valid_ff;
   logic [tpl_pkg::DIV_N_W-1:0] mm_n2_ff, mm_n2_in;
   tpl_pkg::cfg_type           mm_len_ff;
   logic [tpl_pkg::NUM_W-1:0]  num_full;

   // Divider outputs and saturate stage.
   logic                      d_valid;
   tpl_pkg::quot_type         d_quot;
   tpl_pkg::sat_type          q_ext, q_neg;
   logic                      s_valid_ff;
   logic [tpl_pkg::LEVEL_BITS-1:0] s_level_ff, s_level_in;

   // Output register and skid register.
   logic out_valid_ff, out_valid_in;
   logic [tpl_pkg::LEVEL_BITS-1:0] out_level_ff, out_level_in;
   logic skid_valid_ff, skid_valid_in;
   logic [tpl_pkg::LEVEL_BITS-1:0] skid_level_ff, skid_level_in;

   // Register write decode. The next values show the defaults while reset is high.
   always_comb begin
      amp_in  = amp_ff;
      high_in = high_ff;
      low_in  = low_ff;
      rise_in = rise_ff;
      fall_in = fall_ff;
      dly_in  = dly_ff;
      if (reset) begin
         amp_in  = tpl_pkg::RST_AMPLITUDE;
         high_in = tpl_pkg::RST_HIGH_TIME;
         low_in  = tpl_pkg::RST_LOW_TIME;
         rise_in = tpl_pkg::RST_RISE_TIME;
         fall_in = tpl_pkg::RST_FALL_TIME;
         dly_in  = tpl_pkg::RST_START_DELAY;
      end else if (csr_we) begin
         unique case (csr_index)
            tpl_pkg::CSR_AMPLITUDE:   amp_in  = csr_wdata[tpl_pkg::AMP_W-1:0];
            tpl_pkg::CSR_HIGH_TIME:   high_in = csr_wdata;
            tpl_pkg::CSR_LOW_TIME:    low_in  = csr_wdata;
            tpl_pkg::CSR_RISE_TIME:   rise_in = csr_wdata;
            tpl_pkg::CSR_FALL_TIME:   fall_in = csr_wdata;
            tpl_pkg::CSR_START_DELAY: dly_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff  <= tpl_pkg::RST_AMPLITUDE;
         high_ff <= tpl_pkg::RST_HIGH_TIME;
         low_ff  <= tpl_pkg::RST_LOW_TIME;
         rise_ff <= tpl_pkg::RST_RISE_TIME;
         fall_ff <= tpl_pkg::RST_FALL_TIME;
         dly_ff  <= tpl_pkg::RST_START_DELAY;
      end else begin
         amp_ff  <= amp_in;
         high_ff <= high_in;
         low_ff  <= low_in;
         rise_ff <= rise_in;
         fall_ff <= fall_in;
         dly_ff  <= dly_in;
      end
   end

   // Derived values follow the next register values, so they are valid right after reset.
   always_comb begin
      neg_in    = amp_in[tpl_pkg::AMP_W-1];
      mag_in    = neg_in ? (~amp_in + 1'b1) : amp_in;
      tr_in     = (rise_in < high_in) ? rise_in : high_in;
      tf_in     = (fall_in < low_in) ? fall_in : low_in;
      period_in = {1'b0, high_in} + {1'b0, low_in};
      thf_in    = {1'b0, high_in} + {1'b0, tf_in};
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      tr_ff     <= tr_in;
      tf_ff     <= tf_in;
      period_ff <= period_in;
      thf_ff    <= thf_in;
   end

   // The whole pipeline advances unless the skid register holds a response.
   assign en             = !skid_valid_ff;
   assign req_chan.ready = en;

   // Entry stage: time since the start delay and whether the pulse is running.
   always_comb begin
      t_ext            = tpl_pkg::CMP_W'(req_chan.time_now);
      dly_ext          = tpl_pkg::CMP_W'(dly_ff);
      diff             = t_ext - dly_ext;
      a_dt_in          = diff[tpl_pkg::TIME_BITS-1:0];
      a_side_in.live   = (t_ext > dly_ext) && (period_ff != '0);
      a_side_in.factor = req_chan.source_factor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_dt_ff   <= a_dt_in;
         a_side_ff <= a_side_in;
      end
   end

   // Phase within the period.
   tpl_mod_pipe u_mod (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (a_valid_ff),
      .in_dividend (a_dt_ff),
      .in_side     (a_side_ff),
      .period      (period_ff),
      .out_valid   (m_valid),
      .out_phase   (m_phase),
      .out_side    (m_side)
   );

   // Classify stage: pick the ramp position and length, and scale the amplitude by the factor.
   always_comb begin
      fall_x = thf_ff - m_phase;
      if (!m_side.live) begin
         c_x_in   = '0;
         c_len_in = tpl_pkg::CFG_W'(1);
      end else if (m_phase < {1'b0, tr_ff}) begin
         c_x_in   = m_phase[tpl_pkg::CFG_W-1:0];
         c_len_in = tr_ff;
      end else if (m_phase < {1'b0, high_ff}) begin
         c_x_in   = tpl_pkg::CFG_W'(1);
         c_len_in = tpl_pkg::CFG_W'(1);
      end else if (m_phase < thf_ff) begin
         c_x_in   = fall_x[tpl_pkg::CFG_W-1:0];
         c_len_in = tf_ff;
      end else begin
         c_x_in   = '0;
         c_len_in = tpl_pkg::CFG_W'(1);
      end
      ms_full = mag_ff * m_side.factor;
      c_ms_in = ms_full[tpl_pkg::PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= m_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_x_ff   <= c_x_in;
         c_len_ff <= c_len_in;
         c_ms_ff  <= c_ms_in;
      end
   end

   // Multiply stage: the Q1.15 scaling drops the low fraction bits before the divide.
   always_comb begin
      num_full = tpl_pkg::NUM_W'(c_ms_ff) * tpl_pkg::NUM_W'(c_x_ff);
      mm_n2_in = num_full[tpl_pkg::NUM_W-1:tpl_pkg::FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mm_valid_ff <= 1'b0;
      end else if (en) begin
         mm_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mm_n2_ff  <= mm_n2_in;
         mm_len_ff <= c_len_ff;
      end
   end

   // Divide by the ramp length.
   tpl_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mm_valid_ff),
      .in_num    (mm_n2_ff),
      .in_len    (mm_len_ff),
      .out_valid (d_valid),
      .out_quot  (d_quot)
   );

   // Saturate stage: apply the amplitude sign and clamp to the output range.
   always_comb begin
      q_ext = tpl_pkg::SAT_W'(d_quot);
      q_neg = ~q_ext + 1'b1;
      if (neg_ff) begin
         if (q_ext > tpl_pkg::SAT_NEG_LIMIT) begin
            s_level_in = tpl_pkg::LEVEL_NEG_LIMIT;
         end else begin
            s_level_in = q_neg[tpl_pkg::LEVEL_BITS-1:0];
         end
      end else begin
         if (q_ext > tpl_pkg::SAT_POS_LIMIT) begin
            s_level_in = tpl_pkg::LEVEL_POS_LIMIT;
         end else begin
            s_level_in = q_ext[tpl_pkg::LEVEL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (en) begin
         s_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_level_ff <= s_level_in;
      end
   end

   // Output register with a skid register behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_level_in  = out_level_ff;
      skid_valid_in = skid_valid_ff;
      skid_level_in = skid_level_ff;
      if (skid_valid_ff) begin
         if (rsp_chan.ready) begin
            out_level_in  = skid_level_ff;
            skid_valid_in = 1'b0;
         end
      end else if (s_valid_ff) begin
         if (!out_valid_ff || rsp_chan.ready) begin
            out_valid_in = 1'b1;
            out_level_in = s_level_ff;
         end else begin
            skid_valid_in = 1'b1;
            skid_level_in = s_level_ff;
         end
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_level_ff  <= out_level_in;
      skid_level_ff <= skid_level_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.drive_level = out_level_ff;

   // The skid register only fills behind a waiting response.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a response while the output register is empty");

   // A finished level that meets a stalled output goes into the skid register intact.
   a_skid_capture: assert property (@(posedge clock) disable iff (reset)
      (en && s_valid_ff && out_valid_ff && !rsp_chan.ready)
      |=> (skid_valid_ff && (skid_level_ff == $past(s_level_ff))))
      else $error("finished level lost on a stalled output");

   // A zero ramp position gives a zero numerator.
   a_zero_position: assert property (@(posedge clock) disable iff (reset)
      (en && c_valid_ff && (c_x_ff == '0)) |=> (mm_n2_ff == '0))
      else $error("zero position did not give a zero numerator");

endmodule
